>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on the clk / rst_n domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Defaults and codes for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 31;

  // Operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DECR    = 2'd1;
  localparam logic [1:0] OP_DEL_MIN = 2'd2;
  // Unused code: ignored, reports the current heap state
  localparam logic [1:0] OP_NOP     = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

endpackage

>>> rtl/core/ihq_ram.sv
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap with stable handles: insert, decrease-key, delete-min.
// ----------------------------------------------------------------------------
// One operation at a time. The heap array, per-handle key, position and tag
// each sit in a RAM with one read and one write port and a registered read.
// Insert walks up one level per step, then places the entry and hands over
// the result; decrease-key first looks up the stored position and key.
// Delete-min reads the children of a level one at a time through the single
// heap read port, left before right. An empty delete-min, an exhausted
// insert or an ignored mode goes straight to the result, a rejected
// decrease after its lookup. A new beat is taken while the previous result
// still waits on the output register; a second finished result then holds
// the input until the first one leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_heap_queue #(
  parameter int CAPACITY = ihq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ihq_pkg::KEY_BITS_DEF,
  localparam int HW      = $clog2(CAPACITY),
  localparam int IN_RAW  = 2 + HW + KEY_BITS + 32,
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = 2 + HW + KEY_BITS + 32 + HW + KEY_BITS + 1,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mode[2], handle[HW], priority_req[KEY_BITS], tag[32]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status[2], out_handle[HW], out_priority[KEY_BITS], out_tag[32],
  // count[HW], min_priority[KEY_BITS], is_empty[1]
  output logic [OUT_W-1:0] out_tdata
);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [HW-1:0]       hnd;
  } slot_t;

  localparam int SW = KEY_BITS + HW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_DROOT = 4'd4;
  localparam logic [3:0] S_DLAST = 4'd5;
  localparam logic [3:0] S_DNL   = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Control state
  logic [3:0]          state_r, state_nxt;
  logic [HW-1:0]       count_r, count_nxt;
  logic [HW:0]         next_r, next_nxt;
  logic                out_valid_r, out_valid_nxt;
  // Working payload
  logic [KEY_BITS-1:0] root_r, root_nxt;
  logic [HW-1:0]       pos_r, pos_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HW-1:0]       hnd_r, hnd_nxt;
  slot_t               lft_r, lft_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [HW-1:0]       res_handle_r, res_handle_nxt;
  logic [KEY_BITS-1:0] res_prio_r, res_prio_nxt;
  logic [31:0]         res_tag_r, res_tag_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // Memory ports
  logic                heap_we;
  logic [HW-1:0]       heap_waddr, heap_raddr;
  slot_t               heap_wdata, heap_rdata;
  logic                pos_we;
  logic [HW-1:0]       pos_waddr, pos_wdata, pos_raddr, pos_rdata;
  logic                key_we;
  logic [HW-1:0]       key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic                pay_we;
  logic [HW-1:0]       pay_waddr, pay_raddr;
  logic [31:0]         pay_wdata, pay_rdata;

  // Input fields
  logic [1:0]          in_mode;
  logic [HW-1:0]       in_handle;
  logic [KEY_BITS-1:0] in_prio;
  logic [31:0]         in_tag;
  logic                in_acc;

  // Sift-down, sift-up, insert and decrease helpers
  logic [HW:0]         j_wide;
  logic [HW-1:0]       j_idx;
  logic                sel_right;
  slot_t               ch_slot;
  logic [HW-1:0]       ch_idx;
  logic [HW-1:0]       ins_pos;
  logic [HW-1:0]       half_pos;
  logic                dec_ok;

  assign in_mode   = in_tdata[1:0];
  assign in_handle = in_tdata[HW+1:2];
  assign in_prio   = in_tdata[HW+KEY_BITS+1:HW+2];
  assign in_tag    = in_tdata[HW+KEY_BITS+33:HW+KEY_BITS+2];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ihq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );
  ihq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );
  ihq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  ihq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_pay (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_rdata)
  );

  // Child selection for sift-down, insert position, parent index, decrease check
  always_comb begin
    j_wide    = {pos_r, 1'b0};
    j_idx     = j_wide[HW-1:0];
    sel_right = (state_r == S_DNR) && (lft_r.key > heap_rdata.key);
    if (sel_right) begin
      ch_slot = heap_rdata;
      ch_idx  = j_idx + HW'(1);
    end else if (state_r == S_DNR) begin
      ch_slot = lft_r;
      ch_idx  = j_idx;
    end else begin
      ch_slot = heap_rdata;
      ch_idx  = j_idx;
    end
    ins_pos  = count_r + HW'(1);
    half_pos = pos_r >> 1;
    dec_ok   = (hnd_r != '0) && ({1'b0, hnd_r} < next_r) && (pos_rdata != '0)
               && (key_r < key_rdata);
  end

  // Operation sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    next_nxt       = next_r;
    out_valid_nxt  = out_valid_r;
    root_nxt       = root_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    hnd_nxt        = hnd_r;
    lft_nxt        = lft_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_prio_nxt   = res_prio_r;
    res_tag_nxt    = res_tag_r;
    out_data_nxt   = out_data_r;
    heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_raddr = '0;
    pos_we  = 1'b0; pos_waddr  = '0; pos_wdata  = '0; pos_raddr  = '0;
    key_we  = 1'b0; key_waddr  = '0; key_wdata  = '0; key_raddr  = '0;
    pay_we  = 1'b0; pay_waddr  = '0; pay_wdata  = '0; pay_raddr  = '0;

    // Drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = ihq_pkg::ST_OK;
          res_handle_nxt = '0;
          res_prio_nxt   = '0;
          res_tag_nxt    = '0;
          key_nxt        = in_prio;
          case (in_mode)
            ihq_pkg::OP_INSERT: begin
              if (next_r >= (HW+1)'(CAPACITY)) begin
                res_status_nxt = ihq_pkg::ST_EXHAUSTED;
                state_nxt      = S_DONE;
              end else begin
                hnd_nxt        = next_r[HW-1:0];
                res_handle_nxt = next_r[HW-1:0];
                next_nxt       = next_r + (HW+1)'(1);
                count_nxt      = ins_pos;
                pos_nxt        = ins_pos;
                pay_we         = 1'b1;
                pay_waddr      = next_r[HW-1:0];
                pay_wdata      = in_tag;
                if (ins_pos == HW'(1)) begin
                  state_nxt = S_FIN;
                end else begin
                  heap_raddr = ins_pos >> 1;
                  state_nxt  = S_UP;
                end
              end
            end
            ihq_pkg::OP_DECR: begin
              hnd_nxt   = in_handle;
              pos_raddr = in_handle;
              key_raddr = in_handle;
              state_nxt = S_DEC;
            end
            ihq_pkg::OP_DEL_MIN: begin
              if (count_r == '0) begin
                res_status_nxt = ihq_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                heap_raddr = HW'(1);
                state_nxt  = S_DROOT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Check the decrease against handle range, stored position and key
      S_DEC: begin
        if (!dec_ok) begin
          res_status_nxt = ihq_pkg::ST_REJECTED;
          state_nxt      = S_DONE;
        end else begin
          res_handle_nxt = hnd_r;
          pos_nxt        = pos_rdata;
          if (pos_rdata == HW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            heap_raddr = pos_rdata >> 1;
            state_nxt  = S_UP;
          end
        end
      end

      // Sift up: move a strictly greater parent down one level
      S_UP: begin
        if (heap_rdata.key > key_r) begin
          heap_we    = 1'b1;
          heap_waddr = pos_r;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.hnd;
          pos_wdata  = pos_r;
          pos_nxt    = half_pos;
          if (half_pos > HW'(1)) begin
            heap_raddr = half_pos >> 1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Place the moving entry
      S_FIN: begin
        heap_we    = 1'b1;
        heap_waddr = pos_r;
        heap_wdata = '{key: key_r, hnd: hnd_r};
        pos_we     = 1'b1;
        pos_waddr  = hnd_r;
        pos_wdata  = pos_r;
        key_we     = 1'b1;
        key_waddr  = hnd_r;
        key_wdata  = key_r;
        if (pos_r == HW'(1)) begin
          root_nxt = key_r;
        end
        state_nxt = S_DONE;
      end

      // Capture the root, mark it removed, fetch the last entry
      S_DROOT: begin
        res_handle_nxt = heap_rdata.hnd;
        res_prio_nxt   = heap_rdata.key;
        pay_raddr      = heap_rdata.hnd;
        heap_raddr     = count_r;
        pos_we         = 1'b1;
        pos_waddr      = heap_rdata.hnd;
        pos_wdata      = '0;
        state_nxt      = S_DLAST;
      end

      S_DLAST: begin
        res_tag_nxt = pay_rdata;
        count_nxt   = count_r - HW'(1);
        key_nxt     = heap_rdata.key;
        hnd_nxt     = heap_rdata.hnd;
        pos_nxt     = HW'(1);
        if (count_r == HW'(1)) begin
          state_nxt = S_DONE;
        end else if (count_r == HW'(2)) begin
          state_nxt = S_FIN;
        end else begin
          heap_raddr = HW'(2);
          state_nxt  = S_DNL;
        end
      end

      // Sift down: left child in, fetch right if present, then move the smaller child up or place
      S_DNL, S_DNR: begin
        if (state_r == S_DNL && j_wide < {1'b0, count_r}) begin
          lft_nxt    = heap_rdata;
          heap_raddr = j_idx + HW'(1);
          state_nxt  = S_DNR;
        end else if (ch_slot.key >= key_r) begin
          state_nxt = S_FIN;
        end else begin
          heap_we    = 1'b1;
          heap_waddr = pos_r;
          heap_wdata = ch_slot;
          pos_we     = 1'b1;
          pos_waddr  = ch_slot.hnd;
          pos_wdata  = pos_r;
          if (pos_r == HW'(1)) begin
            root_nxt = ch_slot.key;
          end
          pos_nxt = ch_idx;
          if (ch_idx <= (count_r >> 1)) begin
            heap_raddr = ch_idx << 1;
            state_nxt  = S_DNL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({(count_r == '0),
                                  (count_r == '0) ? '0 : root_r,
                                  count_r, res_tag_r, res_prio_r,
                                  res_handle_r, res_status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_r      <= (HW+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    root_r       <= root_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    hnd_r        <= hnd_nxt;
    lft_r        <= lft_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_prio_r   <= res_prio_nxt;
    res_tag_r    <= res_tag_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Heap size never exceeds the number of handles issued
  `ASSERT_CLK(a_count_vs_handles, ({1'b0, count_r} < next_r), "count exceeds issued handles")
  // Sift-up never runs at the root
  `ASSERT_CLK(a_up_not_root, (state_r == S_UP) |-> (pos_r > HW'(1)), "sift-up at root")
  // Sift-down only on a non-empty heap
  `ASSERT_CLK(a_down_nonempty, (state_r == S_DNL || state_r == S_DNR) |-> (count_r != '0),
              "sift-down on empty heap")
  // Heap size holds while no operation runs
  `ASSERT_CLK(a_count_idle, (state_r == S_IDLE && !in_acc) |=> $stable(count_r),
              "count changed while idle")

endmodule

>>> verif/indexed_min_heap_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_tb
// Self-checking bench for the indexed min-heap queue. A scoreboard keeps its
// own heap, per-handle tables and handle counter, predicts one result beat
// per accepted input beat, and checks every output beat field by field.
// Directed corner cases come first, then weighted random operations with
// random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_tb;

  localparam int CAP      = 1024;
  localparam int N_RANDOM = 1930;
  localparam int WDOG_MAX = 5000;

  typedef struct packed {
    logic        is_empty;
    logic [30:0] min_priority;
    logic [9:0]  count;
    logic [31:0] tag;
    logic [30:0] priority_out;
    logic [9:0]  handle;
    logic [1:0]  status;
  } heap_result_t;

  // Predictor of the heap queue and store of pending results
  class heap_scoreboard;
    logic [30:0]  slot_key [CAP];
    int           slot_hnd [CAP];
    logic [30:0]  elem_key [CAP];
    int           elem_pos [CAP];
    logic [31:0]  elem_tag [CAP];
    int           heap_cnt;
    int           next_hnd;
    heap_result_t pending[$];
    int           errors;
    int           n_checked;
    int           n_status [4];

    function new();
      heap_cnt = 0;
      next_hnd = 1;
      errors   = 0;
      n_checked = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    // Walk handle h with key k up from position p
    function void lift(int p, int h, logic [30:0] k);
      while (p > 1 && slot_key[p / 2] > k) begin
        slot_key[p] = slot_key[p / 2];
        slot_hnd[p] = slot_hnd[p / 2];
        elem_pos[slot_hnd[p]] = p;
        p = p / 2;
      end
      slot_key[p] = k;
      slot_hnd[p] = h;
      elem_pos[h] = p;
      elem_key[h] = k;
    endfunction

    function void note_input(logic [79:0] beat);
      logic [1:0]   mode;
      logic [9:0]   hreq;
      logic [30:0]  k;
      logic [31:0]  tg;
      heap_result_t r;
      logic [30:0]  last_key;
      int           last_hnd;
      int           i;
      int           j;
      int           n;
      mode = beat[1:0];
      hreq = beat[11:2];
      k    = beat[42:12];
      tg   = beat[74:43];
      r    = '0;
      r.status = ihq_pkg::ST_OK;
      case (mode)
        ihq_pkg::OP_INSERT: begin
          if (next_hnd >= CAP) begin
            r.status = ihq_pkg::ST_EXHAUSTED;
          end else begin
            r.handle = next_hnd[9:0];
            elem_tag[next_hnd] = tg;
            heap_cnt++;
            lift(heap_cnt, next_hnd, k);
            next_hnd++;
          end
        end
        ihq_pkg::OP_DECR: begin
          if (hreq == 0 || hreq >= next_hnd || elem_pos[hreq] == 0 || k >= elem_key[hreq]) begin
            r.status = ihq_pkg::ST_REJECTED;
          end else begin
            lift(elem_pos[hreq], hreq, k);
            r.handle = hreq;
          end
        end
        ihq_pkg::OP_DEL_MIN: begin
          if (heap_cnt == 0) begin
            r.status = ihq_pkg::ST_EMPTY;
          end else begin
            r.handle       = slot_hnd[1][9:0];
            r.priority_out = slot_key[1];
            r.tag          = elem_tag[slot_hnd[1]];
            elem_pos[slot_hnd[1]] = 0;
            last_key = slot_key[heap_cnt];
            last_hnd = slot_hnd[heap_cnt];
            heap_cnt--;
            n = heap_cnt;
            if (n > 0) begin
              i = 1;
              while (i <= n / 2) begin
                j = 2 * i;
                if (j < n && slot_key[j] > slot_key[j + 1]) j++;
                if (slot_key[j] >= last_key) break;
                slot_key[i] = slot_key[j];
                slot_hnd[i] = slot_hnd[j];
                elem_pos[slot_hnd[i]] = i;
                i = j;
              end
              slot_key[i] = last_key;
              slot_hnd[i] = last_hnd;
              elem_pos[last_hnd] = i;
            end
          end
        end
        default: ;
      endcase
      r.count        = heap_cnt[9:0];
      r.min_priority = (heap_cnt > 0) ? slot_key[1] : '0;
      r.is_empty     = (heap_cnt == 0);
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task check_result(logic [119:0] beat);
      heap_result_t got;
      heap_result_t want;
      got = beat[116:0];
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 1);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      n_status[want.status]++;
      if (got.status != want.status) report("status", want.status, got.status);
      if (got.handle != want.handle) report("out_handle", want.handle, got.handle);
      if (got.priority_out != want.priority_out)
        report("out_priority", want.priority_out, got.priority_out);
      if (got.tag != want.tag) report("out_tag", want.tag, got.tag);
      if (got.count != want.count) report("count", want.count, got.count);
      if (got.min_priority != want.min_priority)
        report("min_priority", want.min_priority, got.min_priority);
      if (got.is_empty != want.is_empty) report("is_empty", want.is_empty, got.is_empty);
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  // mode[2], handle[10], priority_req[31], tag[32]
  logic [79:0]   in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  // status[2], out_handle[10], out_priority[31], out_tag[32],
  // count[10], min_priority[31], is_empty[1]
  logic [119:0]  out_tdata;

  heap_scoreboard sb;
  int  sent_beats;
  int  idle_cycles;
  bit  no_idle;
  bit  holdoff_done;

  indexed_min_heap_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [79:0] pack_op(logic [1:0] mode, logic [9:0] h,
                                          logic [30:0] k, logic [31:0] tg);
    return {5'b0, tg, k, h, mode};
  endfunction

  // Random key: mostly a small range to force ties, sometimes full width
  function automatic logic [30:0] rand_key();
    if ($urandom_range(0, 9) < 7) return 31'($urandom_range(0, 63));
    return 31'($urandom);
  endfunction

  // Offer one beat on the input stream, with random idle cycles first
  task automatic send_beat(logic [79:0] beat);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(beat);
    sent_beats++;
  endtask

  // Drive out_tready: random stalls, one long hold-off while input keeps coming
  initial begin
    out_tready = 1'b0;
    holdoff_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!holdoff_done && sent_beats >= 300) begin
        holdoff_done = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        out_tready <= 1'b1;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // Check every output beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Stop on a long stretch without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d results pending", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          pick;
    logic [9:0]  h;
    logic [30:0] k;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    sent_beats  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: empty delete, extreme keys and tags, ties, rejects
    send_beat(pack_op(ihq_pkg::OP_DEL_MIN, 10'h3FF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_beat(pack_op(ihq_pkg::OP_INSERT, 10'h3FF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_beat(pack_op(ihq_pkg::OP_DEL_MIN, 10'd0, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd1, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DEL_MIN, 10'd0, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_INSERT, 10'd0, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_INSERT, 10'd0, 31'd5, 32'h1234_5678));
    send_beat(pack_op(ihq_pkg::OP_INSERT, 10'd0, 31'd5, 32'h8765_4321));
    send_beat(pack_op(ihq_pkg::OP_INSERT, 10'd0, 31'h7FFF_FFFF, 32'hA5A5_A5A5));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd0, 31'd1, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'h3FF, 31'd1, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd4, 31'd5, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd5, 31'd5, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd5, 31'd6, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd5, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_NOP, 10'h3FF, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    repeat (5) send_beat(pack_op(ihq_pkg::OP_DEL_MIN, 10'd0, 31'd0, 32'd0));
    send_beat(pack_op(ihq_pkg::OP_DECR, 10'd5, 31'd0, 32'd0));

    // Weighted random operations; one stretch with no idling on either side
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 700 && n < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 56) begin
        send_beat(pack_op(ihq_pkg::OP_INSERT, 10'($urandom), rand_key(), $urandom));
      end else if (pick < 74) begin
        if (sb.next_hnd > 1) begin
          h = 10'($urandom_range(1, sb.next_hnd - 1));
          k = sb.elem_key[h];
          if (k > 0 && $urandom_range(0, 9) < 8) k = 31'($urandom_range(0, k - 1));
        end else begin
          h = 10'($urandom);
          k = rand_key();
        end
        send_beat(pack_op(ihq_pkg::OP_DECR, h, k, $urandom));
      end else if (pick < 96) begin
        send_beat(pack_op(ihq_pkg::OP_DEL_MIN, 10'($urandom), rand_key(), $urandom));
      end else begin
        send_beat(pack_op(2'($urandom), 10'($urandom), 31'($urandom), $urandom));
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain and let the block settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d empty, %0d exhausted, %0d rejected",
             sb.n_checked, sb.n_status[ihq_pkg::ST_OK], sb.n_status[ihq_pkg::ST_EMPTY],
             sb.n_status[ihq_pkg::ST_EXHAUSTED], sb.n_status[ihq_pkg::ST_REJECTED]);
    $display("Handles issued: %0d, entries left: %0d, mismatches: %0d",
             sb.next_hnd - 1, sb.heap_cnt, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
